>>> rtl/lifeg_pkg.sv
// Shared types, sizes and codes for the life grid engine.
// No dependencies; lifeg_ifs, the top level and lifeg_row_unit refer to this package by scoped name.

package lifeg_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int CFG_W    = 7;
    localparam int COORD_W  = 6;
    localparam int COUNT_W  = 4;
    localparam int ROW_CW   = (ROW_AW + 1 > CFG_W) ? ROW_AW + 1 : CFG_W;

    typedef logic [MAX_COLS-1:0] row_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_ADVANCE = 2'd3
    } req_type_t;

    typedef enum logic {
        CFG_ACTIVE_COLS = 1'b0,
        CFG_ACTIVE_ROWS = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_READ,
        ST_WR_MOD,
        ST_RD_ABOVE,
        ST_RD_HERE,
        ST_RD_BELOW,
        ST_RD_CAPTURE,
        ST_CLR_FIRST,
        ST_CLR_ROW,
        ST_ADV_FIRST,
        ST_ADV_LOAD,
        ST_ADV_ROW,
        ST_RESP
    } state_t;

endpackage

>>> rtl/lifeg_ifs.sv
// Channel interfaces: request, response and configuration write.
// Depends on lifeg_pkg for field types and widths.

interface lifeg_req_if;
    logic                              valid;
    logic                              ready;
    lifeg_pkg::req_type_t              req_type;
    logic [lifeg_pkg::COORD_W-1:0]     col;
    logic [lifeg_pkg::COORD_W-1:0]     row;
    logic                              new_value;

    modport source (output valid, req_type, col, row, new_value, input ready);
    modport sink   (input valid, req_type, col, row, new_value, output ready);
endinterface

interface lifeg_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              cell_alive;
    lifeg_pkg::count_t                 neighbor_count;
    logic                              req_done;

    modport source (output valid, cell_alive, neighbor_count, req_done, input ready);
    modport sink   (input valid, cell_alive, neighbor_count, req_done, output ready);
endinterface

interface lifeg_cfg_if;
    logic                              valid;
    logic                              ready;
    lifeg_pkg::cfg_index_t             index;
    logic [lifeg_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/life_automaton_grid_engine.sv
// Top level of the life grid engine: request sequencer, grid RAM, config registers.
// Depends on lifeg_pkg, lifeg_ifs, lifeg_ram and lifeg_row_unit.

// One request is taken at a time and answered with exactly one response beat. The grid lives
// in a RAM with one write and one registered read port, so the sequencer moves one row per
// cycle: a cell write reads and then modifies its row, a cell read fetches the rows above,
// at and below it and then captures, a clear and an advance step through every active row,
// each followed by the response beat; writes and reads outside the active area finish at
// once. All cells are dead after reset through per-row valid flags, with no clearing pass,
// so requests are taken from the first cycle. The config port is always ready and must only
// be written while no request is in flight.
module life_automaton_grid_engine (
    input  logic         clk,
    input  logic         rst_n,
    lifeg_req_if.sink    req,
    lifeg_rsp_if.source  rsp,
    lifeg_cfg_if.sink    cfg
);

    localparam int AW = lifeg_pkg::ROW_AW;
    localparam int CW = lifeg_pkg::ROW_CW;

    lifeg_pkg::state_t                state_reg, state_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [lifeg_pkg::COORD_W-1:0]    col_reg, col_next;
    logic [lifeg_pkg::COORD_W-1:0]    row_reg, row_next;
    logic                             val_reg, val_next;
    lifeg_pkg::row_t                  prev_reg, prev_next;
    lifeg_pkg::row_t                  curr_reg, curr_next;
    logic                             res_alive_reg, res_alive_next;
    lifeg_pkg::count_t                res_count_reg, res_count_next;
    logic [lifeg_pkg::CFG_W-1:0]      cfg_cols_reg;
    logic [lifeg_pkg::CFG_W-1:0]      cfg_rows_reg;
    logic [lifeg_pkg::MAX_ROWS-1:0]   row_valid_reg;
    logic                             rd_vld_reg;

    logic [lifeg_pkg::CFG_W-1:0]      eff_cols;
    logic [CW-1:0]                    eff_rows;
    lifeg_pkg::row_t                  col_mask;
    lifeg_pkg::row_t                  ram_rdata;
    lifeg_pkg::row_t                  ram_row;
    lifeg_pkg::row_t                  ram_wdata;
    lifeg_pkg::row_t                  curr_masked;
    lifeg_pkg::row_t                  below_row;
    lifeg_pkg::row_t                  next_row;
    lifeg_pkg::count_t                counts [lifeg_pkg::MAX_COLS];
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             ram_we;
    logic [AW-1:0]                    row_a;
    logic [lifeg_pkg::COL_AW-1:0]     col_idx;
    logic [CW-1:0]                    cnt_plus1;
    logic [CW-1:0]                    cnt_plus2;
    logic [CW-1:0]                    below_idx;
    logic                             req_beat;
    logic                             req_inside;
    logic                             area_empty;
    logic                             last_row;

    // Effective active area, saturated at the grid size
    assign eff_cols = (cfg_cols_reg > lifeg_pkg::CFG_W'(lifeg_pkg::MAX_COLS))
                    ? lifeg_pkg::CFG_W'(lifeg_pkg::MAX_COLS) : cfg_cols_reg;
    assign eff_rows = (CW'(cfg_rows_reg) > CW'(lifeg_pkg::MAX_ROWS))
                    ? CW'(lifeg_pkg::MAX_ROWS) : CW'(cfg_rows_reg);

    always_comb
    begin
        for (int i = 0; i < lifeg_pkg::MAX_COLS; i++)
        begin
            col_mask[i] = (lifeg_pkg::CFG_W'(i) < eff_cols);
        end
    end

    assign req_beat   = req.valid && req.ready;
    assign req_inside = (lifeg_pkg::CFG_W'(req.col) < eff_cols) && (CW'(req.row) < eff_rows);
    assign area_empty = (eff_rows == '0) || (eff_cols == '0);

    assign row_a       = AW'(row_reg);
    assign col_idx     = col_reg[lifeg_pkg::COL_AW-1:0];
    assign cnt_plus1   = cnt_reg + 1'b1;
    assign cnt_plus2   = cnt_reg + 2'd2;
    assign last_row    = (cnt_plus1 == eff_rows);
    assign ram_row     = rd_vld_reg ? ram_rdata : '0;
    assign curr_masked = curr_reg & col_mask;
    assign below_idx   = (state_reg == lifeg_pkg::ST_ADV_ROW) ? cnt_plus1 : CW'(row_reg) + 1'b1;
    assign below_row   = (below_idx < eff_rows) ? (ram_row & col_mask) : '0;

    lifeg_ram #(
        .WIDTH (lifeg_pkg::MAX_COLS),
        .DEPTH (lifeg_pkg::MAX_ROWS)
    ) u_grid (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wr_addr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    lifeg_row_unit u_row_unit (
        .above    (prev_reg),
        .here     (curr_masked),
        .below    (below_row),
        .counts   (counts),
        .next_row (next_row)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lifeg_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    unique case (req.req_type)
                        lifeg_pkg::REQ_WRITE:
                            state_next = req_inside ? lifeg_pkg::ST_WR_READ : lifeg_pkg::ST_RESP;
                        lifeg_pkg::REQ_READ:
                            state_next = req_inside ? lifeg_pkg::ST_RD_ABOVE : lifeg_pkg::ST_RESP;
                        lifeg_pkg::REQ_CLEAR:
                            state_next = area_empty ? lifeg_pkg::ST_RESP : lifeg_pkg::ST_CLR_FIRST;
                        lifeg_pkg::REQ_ADVANCE:
                            state_next = area_empty ? lifeg_pkg::ST_RESP : lifeg_pkg::ST_ADV_FIRST;
                        default:
                            state_next = lifeg_pkg::ST_RESP;
                    endcase
                end
            end
            lifeg_pkg::ST_WR_READ:    state_next = lifeg_pkg::ST_WR_MOD;
            lifeg_pkg::ST_WR_MOD:     state_next = lifeg_pkg::ST_RESP;
            lifeg_pkg::ST_RD_ABOVE:   state_next = lifeg_pkg::ST_RD_HERE;
            lifeg_pkg::ST_RD_HERE:    state_next = lifeg_pkg::ST_RD_BELOW;
            lifeg_pkg::ST_RD_BELOW:   state_next = lifeg_pkg::ST_RD_CAPTURE;
            lifeg_pkg::ST_RD_CAPTURE: state_next = lifeg_pkg::ST_RESP;
            lifeg_pkg::ST_CLR_FIRST:  state_next = lifeg_pkg::ST_CLR_ROW;
            lifeg_pkg::ST_CLR_ROW:
                state_next = last_row ? lifeg_pkg::ST_RESP : lifeg_pkg::ST_CLR_ROW;
            lifeg_pkg::ST_ADV_FIRST:  state_next = lifeg_pkg::ST_ADV_LOAD;
            lifeg_pkg::ST_ADV_LOAD:   state_next = lifeg_pkg::ST_ADV_ROW;
            lifeg_pkg::ST_ADV_ROW:
                state_next = last_row ? lifeg_pkg::ST_RESP : lifeg_pkg::ST_ADV_ROW;
            lifeg_pkg::ST_RESP:
                state_next = rsp.ready ? lifeg_pkg::ST_IDLE : lifeg_pkg::ST_RESP;
            default:                  state_next = lifeg_pkg::ST_IDLE;
        endcase
    end

    // RAM control
    always_comb
    begin
        ram_we    = 1'b0;
        rd_addr   = '0;
        wr_addr   = cnt_reg[AW-1:0];
        ram_wdata = ram_row;
        unique case (state_reg)
            lifeg_pkg::ST_WR_READ:    rd_addr = row_a;
            lifeg_pkg::ST_WR_MOD:
            begin
                ram_we             = 1'b1;
                wr_addr            = row_a;
                ram_wdata[col_idx] = val_reg;
            end
            lifeg_pkg::ST_RD_ABOVE:   rd_addr = row_a - 1'b1;
            lifeg_pkg::ST_RD_HERE:    rd_addr = row_a;
            lifeg_pkg::ST_RD_BELOW:   rd_addr = row_a + 1'b1;
            lifeg_pkg::ST_CLR_ROW:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_row & ~col_mask;
                rd_addr   = cnt_plus1[AW-1:0];
            end
            lifeg_pkg::ST_ADV_LOAD:   rd_addr = cnt_plus1[AW-1:0];
            lifeg_pkg::ST_ADV_ROW:
            begin
                ram_we    = 1'b1;
                ram_wdata = (curr_reg & ~col_mask) | (next_row & col_mask);
                rd_addr   = cnt_plus2[AW-1:0];
            end
            default:
            begin
                ram_we  = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        val_next       = val_reg;
        prev_next      = prev_reg;
        curr_next      = curr_reg;
        res_alive_next = res_alive_reg;
        res_count_next = res_count_reg;
        case (state_reg)
            lifeg_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    col_next       = req.col;
                    row_next       = req.row;
                    val_next       = req.new_value;
                    cnt_next       = '0;
                    res_alive_next = 1'b0;
                    res_count_next = '0;
                end
            end
            lifeg_pkg::ST_RD_HERE:
                prev_next = (row_reg != '0) ? (ram_row & col_mask) : '0;
            lifeg_pkg::ST_RD_BELOW:
                curr_next = ram_row;
            lifeg_pkg::ST_RD_CAPTURE:
            begin
                res_alive_next = curr_masked[col_idx];
                res_count_next = counts[col_idx];
            end
            lifeg_pkg::ST_CLR_ROW:
                cnt_next = cnt_plus1;
            lifeg_pkg::ST_ADV_FIRST:
                prev_next = '0;
            lifeg_pkg::ST_ADV_LOAD:
                curr_next = ram_row;
            lifeg_pkg::ST_ADV_ROW:
            begin
                prev_next = curr_masked;
                curr_next = ram_row;
                cnt_next  = cnt_plus1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lifeg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            cfg_cols_reg  <= lifeg_pkg::CFG_W'(64);
            cfg_rows_reg  <= lifeg_pkg::CFG_W'(64);
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= row_valid_reg[rd_addr];
            if (ram_we)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    lifeg_pkg::CFG_ACTIVE_COLS: cfg_cols_reg <= cfg.data;
                    lifeg_pkg::CFG_ACTIVE_ROWS: cfg_rows_reg <= cfg.data;
                    default:                    cfg_cols_reg <= cfg_cols_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        val_reg       <= val_next;
        prev_reg      <= prev_next;
        curr_reg      <= curr_next;
        res_alive_reg <= res_alive_next;
        res_count_reg <= res_count_next;
    end

    assign req.ready          = (state_reg == lifeg_pkg::ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = (state_reg == lifeg_pkg::ST_RESP);
    assign rsp.cell_alive     = res_alive_reg;
    assign rsp.neighbor_count = res_count_reg;
    assign rsp.req_done       = 1'b1;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("response pending while a request can be taken");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.neighbor_count <= 4'd8))
        else $error("neighbor count above eight");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == lifeg_pkg::ST_WR_MOD || state_reg == lifeg_pkg::ST_CLR_ROW
                    || state_reg == lifeg_pkg::ST_ADV_ROW))
        else $error("grid write outside a writing step");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && req.req_type != lifeg_pkg::REQ_READ) |=> !res_alive_reg)
        else $error("non-read request carries a live cell");

endmodule

>>> rtl/lifeg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lifeg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lifeg_row_unit.sv
// Shared row unit: live-neighbor counts and B3/S23 next state for every column of a row.
// Depends on lifeg_pkg for row and count types.

module lifeg_row_unit (
    input  lifeg_pkg::row_t   above,
    input  lifeg_pkg::row_t   here,
    input  lifeg_pkg::row_t   below,
    output lifeg_pkg::count_t counts [lifeg_pkg::MAX_COLS],
    output lifeg_pkg::row_t   next_row
);

    logic [lifeg_pkg::MAX_COLS+1:0] above_pad;
    logic [lifeg_pkg::MAX_COLS+1:0] here_pad;
    logic [lifeg_pkg::MAX_COLS+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign here_pad  = {1'b0, here, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    always_comb
    begin
        lifeg_pkg::count_t n;
        for (int c = 0; c < lifeg_pkg::MAX_COLS; c++)
        begin
            n = lifeg_pkg::count_t'(above_pad[c]) + lifeg_pkg::count_t'(above_pad[c+1])
              + lifeg_pkg::count_t'(above_pad[c+2]) + lifeg_pkg::count_t'(here_pad[c])
              + lifeg_pkg::count_t'(here_pad[c+2]) + lifeg_pkg::count_t'(below_pad[c])
              + lifeg_pkg::count_t'(below_pad[c+1]) + lifeg_pkg::count_t'(below_pad[c+2]);
            counts[c]   = n;
            next_row[c] = (n == 4'd3) || (here[c] && (n == 4'd2));
        end
    end

endmodule
